// ===== src/assert_macros.svh =====
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, sampled on clk, ignored while rst_n is low
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, ignored while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/tkst_pkg.sv =====
// types and constants of the top-k sorted score table
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    localparam int CMD_W   = 2;
    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;
    localparam int POS_W   = 8;
    localparam int ECNT_W  = 5;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 88;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic        [TAG_W-1:0]   tag_t;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic write_en;
        logic head_ins;
        logic tail_ins;
    } cell_ctrl_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic              accepted;
        logic [ECNT_W-1:0] entry_count;
        score_t            top_score;
        logic              entry_valid;
        tag_t              entry_tag;
        score_t            entry_score;
    } result_t;

endpackage

// ===== src/tkst_cell.sv =====
// one rank of the sorted table: holds an entry, compares and shifts
`timescale 1ns / 1ps

module tkst_cell (
    input  logic                clk,
    input  tkst_pkg::cell_ctrl_t ctrl,
    input  logic                slot_used,
    input  tkst_pkg::score_t    new_score,
    input  tkst_pkg::tag_t      new_tag,
    input  tkst_pkg::score_t    prev_score,
    input  tkst_pkg::tag_t      prev_tag,
    input  logic                prev_shift,
    output tkst_pkg::score_t    score,
    output tkst_pkg::tag_t      tag,
    output logic                shift,
    output logic                gt,
    output logic                ge
);
    import tkst_pkg::*;

    score_t score_reg;
    score_t score_next;
    tag_t   tag_reg;
    tag_t   tag_next;

    assign gt = score_reg > new_score;
    assign ge = score_reg >= new_score;

    // this rank sits at or behind the insertion point
    assign shift = ctrl.head_ins | ~slot_used | (~ctrl.tail_ins & ~gt);

    always_comb
    begin
        score_next = score_reg;
        tag_next   = tag_reg;
        if (ctrl.write_en && shift)
        begin
            if (prev_shift)
            begin
                score_next = prev_score;
                tag_next   = prev_tag;
            end
            else
            begin
                score_next = new_score;
                tag_next   = new_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

    assign score = score_reg;
    assign tag   = tag_reg;

endmodule

// ===== src/top_k_sorted_score_table_unit.sv =====
// top level of the top-k sorted score table
`timescale 1ns / 1ps

// usage
//   input stream s_*: one command per transfer (add, read, clear); every
//   accepted command gives exactly one result transfer on m_*
//   the table is a row of cells, one per rank; on an add every cell compares
//   the offered score with its own entry in parallel and the cells behind the
//   insertion point take their upper neighbour's entry, so the lowest entry
//   falls off the end of a full table
//   result: registered, it appears in the cycle after its command is accepted
//   throughput: one command per cycle while m_tready stays high, set by the
//   single compare-and-shift step of the cell row; a new command is taken in
//   the same cycle as the previous result transfer
//   receiver stall: m_tvalid holds with its data and s_tready drops until
//   the waiting result is taken
//   reset: rst_n low zeroes the stored count and drops m_tvalid; entries and
//   result data are never cleared, only the stored count
//   reads at or beyond the stored count return zeros with entry_valid low

module top_k_sorted_score_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], new_score[33:2], player_tag[49:34], read_position[57:50]
    input  logic [tkst_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_score[31:0], entry_tag[47:32], entry_valid[48], top_score[80:49],
    // entry_count[85:81], accepted[86]
    output logic [tkst_pkg::M_DATA_W-1:0] m_tdata
);
    import tkst_pkg::*;

    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    // unpacked input fields
    logic [CMD_W-1:0] cmd;
    score_t           new_score;
    tag_t             player_tag;
    logic [POS_W-1:0] read_position;

    assign cmd           = s_tdata[1:0];
    assign new_score     = s_tdata[33:2];
    assign player_tag    = s_tdata[49:34];
    assign read_position = s_tdata[57:50];

    logic s_fire;
    assign s_fire = s_tvalid & s_tready;

    // stored count, the only control state of the table besides m_tvalid
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // per-rank signals of the cell row
    score_t                 cell_score [TABLE_SLOTS];
    tag_t                   cell_tag   [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_used;
    logic [TABLE_SLOTS-1:0] cell_shift;
    logic [TABLE_SLOTS-1:0] cell_gt;
    logic [TABLE_SLOTS-1:0] cell_ge;

    cell_ctrl_t ctrl;
    logic       table_full;
    logic       add_ok;
    logic       add_taken;

    // insertion point rules: new score goes to the head when it reaches the
    // top score or the table is empty, to the tail when every stored score is
    // at least as high, otherwise ahead of the first entry not above it
    assign table_full    = (count_reg == CNT_W'(TABLE_SLOTS));
    assign add_ok        = ~table_full | ~cell_ge[TABLE_SLOTS-1];
    assign add_taken     = s_fire & (cmd == CMD_ADD) & add_ok;
    assign ctrl.write_en = add_taken;
    assign ctrl.head_ins = (count_reg == '0) | ~cell_gt[0];
    assign ctrl.tail_ins = &(cell_ge | ~slot_used);

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_SLOTS; gi++)
        begin : g_cell
            assign slot_used[gi] = (count_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                tkst_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .slot_used  (slot_used[gi]),
                    .new_score  (new_score),
                    .new_tag    (player_tag),
                    .prev_score (new_score),
                    .prev_tag   (player_tag),
                    .prev_shift (1'b0),
                    .score      (cell_score[gi]),
                    .tag        (cell_tag[gi]),
                    .shift      (cell_shift[gi]),
                    .gt         (cell_gt[gi]),
                    .ge         (cell_ge[gi])
                );
            end
            else
            begin : g_body
                tkst_cell u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .slot_used  (slot_used[gi]),
                    .new_score  (new_score),
                    .new_tag    (player_tag),
                    .prev_score (cell_score[gi-1]),
                    .prev_tag   (cell_tag[gi-1]),
                    .prev_shift (cell_shift[gi-1]),
                    .score      (cell_score[gi]),
                    .tag        (cell_tag[gi]),
                    .shift      (cell_shift[gi]),
                    .gt         (cell_gt[gi]),
                    .ge         (cell_ge[gi])
                );
            end
        end
    endgenerate

    // count update; a full table keeps its count when an entry is inserted
    always_comb
    begin
        count_next = count_reg;
        if (s_fire)
        begin
            case (cmd)
                CMD_ADD:
                begin
                    if (add_taken && !table_full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // read port: one rank selected by the requested position
    logic   rd_hit;
    score_t rd_score;
    tag_t   rd_tag;

    assign rd_hit = (cmd == CMD_READ) &
                    (CMP_W'(read_position) < CMP_W'(count_reg));

    always_comb
    begin
        rd_score = '0;
        rd_tag   = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (rd_hit && read_position == POS_W'(i))
            begin
                rd_score = cell_score[i];
                rd_tag   = cell_tag[i];
            end
        end
    end

    // top score after this command
    score_t top_next;

    always_comb
    begin
        if (count_next == '0)
        begin
            top_next = '0;
        end
        else if (add_taken && cell_shift[0])
        begin
            top_next = new_score;
        end
        else
        begin
            top_next = cell_score[0];
        end
    end

    // output register
    result_t res_reg;
    result_t res_next;
    logic    m_tvalid_reg;

    always_comb
    begin
        res_next.entry_score = rd_score;
        res_next.entry_tag   = rd_tag;
        res_next.entry_valid = rd_hit;
        res_next.top_score   = top_next;
        res_next.entry_count = ECNT_W'(count_next);
        res_next.accepted    = add_taken;
    end

    assign s_tready = ~m_tvalid_reg | m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_tready)
            begin
                m_tvalid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(result_t)){1'b0}}, res_reg};

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_count_in_range, 1'b1, count_reg <= CNT_W'(TABLE_SLOTS), "count beyond table size")
    `ASSERT_IMPLIES(a_add_no_entry, m_tvalid_reg && res_reg.accepted, !res_reg.entry_valid, "add result carries an entry")
    `ASSERT_NEXT(a_clear_empties, s_fire && cmd == CMD_CLEAR, count_reg == '0 && res_reg.top_score == '0, "clear left entries")
    `ASSERT_NEXT(a_insert_counts, add_taken, count_reg != '0 && res_reg.accepted && m_tvalid_reg, "insert lost")

endmodule

// ===== tb/top_k_checker.sv =====
// checker for the top-k sorted score table: ranking predictor and result compare
`timescale 1ns / 1ps

module top_k_checker
    import tkst_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatches,
    output int                  pending
);

    // predicted table contents, rank zero is the highest score
    score_t  ranked_score [TABLE_SLOTS];
    tag_t    ranked_tag   [TABLE_SLOTS];
    int      ranked_count;
    result_t awaited_results [$];

    assign pending = awaited_results.size();

    function automatic result_t rank_table_apply(input logic [CMD_W-1:0] cmd,
                                                 input score_t            score,
                                                 input tag_t              tag,
                                                 input logic [POS_W-1:0]  rank);
        result_t res;
        int      slot;
        res = '0;
        if (cmd == CMD_ADD) begin
            if (ranked_count < TABLE_SLOTS || score > ranked_score[ranked_count-1]) begin
                // ahead of equal scores, but last when at or below the lowest
                if (ranked_count == 0 || score >= ranked_score[0])
                    slot = 0;
                else if (score <= ranked_score[ranked_count-1])
                    slot = ranked_count;
                else begin
                    slot = 0;
                    while (slot < ranked_count && ranked_score[slot] > score)
                        slot++;
                end
                // a full table drops its lowest entry
                if (ranked_count >= TABLE_SLOTS)
                    ranked_count = TABLE_SLOTS - 1;
                if (slot > ranked_count)
                    slot = ranked_count;
                for (int i = ranked_count; i > slot; i--) begin
                    ranked_score[i] = ranked_score[i-1];
                    ranked_tag[i]   = ranked_tag[i-1];
                end
                ranked_score[slot] = score;
                ranked_tag[slot]   = tag;
                ranked_count++;
                res.accepted = 1'b1;
            end
        end
        else if (cmd == CMD_READ) begin
            if (int'(rank) < ranked_count) begin
                res.entry_score = ranked_score[rank];
                res.entry_tag   = ranked_tag[rank];
                res.entry_valid = 1'b1;
            end
        end
        else if (cmd == CMD_CLEAR)
            ranked_count = 0;
        res.top_score   = (ranked_count > 0) ? ranked_score[0] : '0;
        res.entry_count = ECNT_W'(ranked_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n) begin
            awaited_results.delete();
            ranked_count = 0;
            mismatches   = 0;
        end
        else begin
            // result side first: a result never belongs to the command taken at this edge
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (awaited_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatches++;
                end
                else begin
                    want = awaited_results.pop_front();
                    if (got.entry_score !== want.entry_score) begin
                        $error("entry_score expected %0d got %0d", want.entry_score,
                               got.entry_score);
                        mismatches++;
                    end
                    if (got.entry_tag !== want.entry_tag) begin
                        $error("entry_tag expected %0d got %0d", want.entry_tag, got.entry_tag);
                        mismatches++;
                    end
                    if (got.entry_valid !== want.entry_valid) begin
                        $error("entry_valid expected %0d got %0d", want.entry_valid,
                               got.entry_valid);
                        mismatches++;
                    end
                    if (got.top_score !== want.top_score) begin
                        $error("top_score expected %0d got %0d", want.top_score, got.top_score);
                        mismatches++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count expected %0d got %0d", want.entry_count,
                               got.entry_count);
                        mismatches++;
                    end
                    if (got.accepted !== want.accepted) begin
                        $error("accepted expected %0d got %0d", want.accepted, got.accepted);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(rank_table_apply(s_tdata[1:0], s_tdata[33:2],
                                                           s_tdata[49:34], s_tdata[57:50]));
        end
    end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the top-k sorted score table
`timescale 1ns / 1ps

module testbench;

    import tkst_pkg::*;

    // command code the block must leave as a no-op
    localparam logic [CMD_W-1:0] CMD_IDLE_CODE = 2'd3;

    localparam int RANDOM_COMMANDS = 800;
    localparam int TIMEOUT_CYCLES  = 200000;

    localparam score_t SCORE_MAX = 32'sh7FFF_FFFF;
    localparam score_t SCORE_MIN = 32'sh8000_0000;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // cmd, new_score, player_tag, read_position from bit 0 up, zero padded
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // entry_score, entry_tag, entry_valid, top_score, entry_count, accepted from bit 0 up
    logic [M_DATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int cycle_count = 0;
    bit no_idling   = 1'b0;

    always #4 clk = ~clk;

    top_k_sorted_score_table_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    top_k_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // receiver stalls about one cycle in five, never inside the calm stretch
    always @(posedge clk)
        m_tready <= no_idling || ($urandom_range(0, 99) >= 20);

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // one command transfer; called at a rising edge, returns at the accepting edge
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input score_t score,
                                 input tag_t tag, input logic [POS_W-1:0] rank);
        int gap;
        if (!no_idling && $urandom_range(0, 99) < 20) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, rank, tag, score, cmd};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // sender holds off until every outstanding result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // random command biased towards a well filled table with many score ties
    task automatic issue_random_command();
        logic [CMD_W-1:0] cmd;
        score_t           score;
        logic [POS_W-1:0] rank;
        int               pick;
        pick = $urandom_range(0, 99);
        if (pick < 56)
            cmd = CMD_ADD;
        else if (pick < 93)
            cmd = CMD_READ;
        else if (pick < 97)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_IDLE_CODE;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            score = score_t'($urandom_range(0, 40)) - 20;
        else if (pick < 85)
            score = $urandom;
        else begin
            case ($urandom_range(0, 3))
                0:       score = SCORE_MAX;
                1:       score = SCORE_MIN;
                2:       score = '0;
                default: score = -1;
            endcase
        end
        // mostly ranks near the table size, sometimes the full position range
        rank = ($urandom_range(0, 99) < 80) ? POS_W'($urandom_range(0, TABLE_SLOTS + 1))
                                            : POS_W'($urandom);
        issue_command(cmd, score, tag_t'($urandom), rank);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, ties at both ends, unused code, clear
        issue_command(CMD_READ, '0, '0, 8'd0);
        issue_command(CMD_ADD, SCORE_MAX, 16'hFFFF, 8'hFF);
        issue_command(CMD_ADD, SCORE_MIN, 16'h0000, 8'h00);
        issue_command(CMD_ADD, SCORE_MAX, 16'h1111, 8'h00);
        issue_command(CMD_ADD, SCORE_MIN, 16'h2222, 8'h00);
        issue_command(CMD_READ, '0, '0, 8'd0);
        issue_command(CMD_READ, '0, '0, 8'd3);
        issue_command(CMD_READ, '0, '0, 8'd4);
        issue_command(CMD_READ, '0, '0, 8'd255);
        issue_command(CMD_IDLE_CODE, SCORE_MIN, 16'hFFFF, 8'hFF);
        // fill up to the full table
        for (int i = 0; i < TABLE_SLOTS - 4; i++)
            issue_command(CMD_ADD, score_t'(i * 10 - 50), tag_t'(16'h100 + i), 8'd0);
        // full table: head insert drops the lowest, a rejected add at the lowest score, then an add above it
        issue_command(CMD_ADD, SCORE_MAX, 16'hABCD, 8'd0);
        issue_command(CMD_ADD, SCORE_MIN, 16'h5555, 8'd0);
        issue_command(CMD_ADD, score_t'(-60), 16'h6666, 8'd0);
        issue_command(CMD_READ, '0, '0, 8'(TABLE_SLOTS - 1));
        issue_command(CMD_READ, '0, '0, 8'(TABLE_SLOTS));
        issue_command(CMD_CLEAR, SCORE_MAX, 16'hFFFF, 8'hFF);
        issue_command(CMD_READ, '0, '0, 8'd0);

        // random part with a calm stretch and one full drain half way
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            no_idling = (n >= 200 && n < 350);
            if (n == 400)
                drain_results();
            issue_random_command();
        end
        no_idling = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
